@@ hdl/bfb_pkg.sv @@
// ----------------------------------------------------------------------------
// Beacon frame builder package
// Shared types, constants and helper functions for the frame builder.
// ----------------------------------------------------------------------------
package bfb_pkg;

  // Header characters that open every frame.
  localparam logic [7:0] HDR_CHAR0 = 8'h4E;  // 'N'
  localparam logic [7:0] HDR_CHAR1 = 8'h65;  // 'e'

  // Largest message length that still fits the length byte in hex mode.
  localparam logic [7:0] HEX_LEN_MAX = 8'd127;

  // Most result bytes one input transaction can cause.
  localparam int unsigned MAX_RESULTS = 7;
  localparam int unsigned CNT_W = 3;

  typedef logic [CNT_W-1:0] res_cnt_t;

  // Result bytes produced by one input transaction, in emission order.
  typedef struct packed {
    res_cnt_t                    count;        // number of valid entries
    logic [MAX_RESULTS-1:0][7:0] bytes;        // entry bytes
    logic                        frame_close;  // last entry ends the frame
    logic                        err;          // single length error entry
  } result_list_t;

  // Uppercase ASCII hex character of the low nibble.
  function automatic logic [7:0] nibble_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'd0, v};
    end else begin
      r = 8'h41 + {4'd0, v} - 8'd10;
    end
    return r;
  endfunction

endpackage

@@ hdl/bfb_encode.sv @@
// ----------------------------------------------------------------------------
// Beacon frame builder encoder
// Turns one input transaction into its list of result bytes and keeps the
// running Fletcher-style sums (modulo 256) and the frame drop flag.
// ----------------------------------------------------------------------------
module bfb_encode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  hex_mode,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic [7:0]            frame_length,
  input  logic                  first_item,
  input  logic                  last_item,
  output bfb_pkg::result_list_t result_list
);

  logic [7:0] sum_first_r, sum_first_nxt;
  logic [7:0] sum_second_r, sum_second_nxt;
  logic       dropping_r, dropping_nxt;

  logic       bad_len;
  logic [7:0] base1, base2;
  logic [7:0] pay0, pay1;
  logic [7:0] s1_a, s2_a, s1_b, s2_b;
  logic [7:0] len_byte;

  // Length check and payload characters.
  always_comb begin
    bad_len  = (frame_length == 8'd0) ||
               (hex_mode && (frame_length > bfb_pkg::HEX_LEN_MAX));
    len_byte = hex_mode ? {frame_length[6:0], 1'b0} : frame_length;
    pay0     = hex_mode ? bfb_pkg::nibble_char(data_byte[7:4]) : data_byte;
    pay1     = bfb_pkg::nibble_char(data_byte[3:0]);
  end

  // Running sums over the one or two payload bytes of this transaction.
  always_comb begin
    base1 = first_item ? 8'd0 : sum_first_r;
    base2 = first_item ? 8'd0 : sum_second_r;
    s1_a  = base1 + pay0;
    s2_a  = base2 + s1_a;
    s1_b  = s1_a + pay1;
    s2_b  = s2_a + s1_b;
  end

  // Assemble the result list in emission order.
  always_comb begin
    bfb_pkg::res_cnt_t n;
    bfb_pkg::res_cnt_t n1;
    logic [7:0]        fs1, fs2;
    n           = '0;
    n1          = '0;
    fs1         = hex_mode ? s1_b : s1_a;
    fs2         = hex_mode ? s2_b : s2_a;
    result_list = '0;
    if (first_item && bad_len) begin
      result_list.count       = bfb_pkg::res_cnt_t'(1);
      result_list.frame_close = 1'b1;
      result_list.err         = 1'b1;
    end else if (first_item || !dropping_r) begin
      if (first_item) begin
        result_list.bytes[0] = bfb_pkg::HDR_CHAR0;
        result_list.bytes[1] = bfb_pkg::HDR_CHAR1;
        result_list.bytes[2] = len_byte;
        n = bfb_pkg::res_cnt_t'(3);
      end
      result_list.bytes[n] = pay0;
      n = n + 1'b1;
      if (hex_mode) begin
        result_list.bytes[n] = pay1;
        n = n + 1'b1;
      end
      if (last_item) begin
        n1 = n + 1'b1;
        result_list.bytes[n]  = fs1;
        result_list.bytes[n1] = fs2;
        n = n + 2'd2;
        result_list.frame_close = 1'b1;
      end
      result_list.count = n;
    end
  end

  // Next state of the sums and the drop flag.
  always_comb begin
    sum_first_nxt  = sum_first_r;
    sum_second_nxt = sum_second_r;
    dropping_nxt   = dropping_r;
    if (first_item && bad_len) begin
      sum_first_nxt  = 8'd0;
      sum_second_nxt = 8'd0;
      dropping_nxt   = 1'b1;
    end else if (first_item || !dropping_r) begin
      sum_first_nxt  = hex_mode ? s1_b : s1_a;
      sum_second_nxt = hex_mode ? s2_b : s2_a;
      dropping_nxt   = 1'b0;
    end
  end

  // State registers, updated once per accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_first_r  <= 8'd0;
      sum_second_r <= 8'd0;
      dropping_r   <= 1'b0;
    end else if (accept) begin
      sum_first_r  <= sum_first_nxt;
      sum_second_r <= sum_second_nxt;
      dropping_r   <= dropping_nxt;
    end
  end

endmodule

@@ hdl/bfb_emit.sv @@
// ----------------------------------------------------------------------------
// Beacon frame builder result emitter
// Holds the result list of one transaction and sends it one byte per
// output transaction; takes the next list as the last byte leaves.
// ----------------------------------------------------------------------------
module bfb_emit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  bfb_pkg::result_list_t list_in,
  output logic                  can_load,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_run_end,
  output logic                  out_frame_end,
  output logic                  out_length_error
);

  bfb_pkg::result_list_t list_r;
  bfb_pkg::res_cnt_t     idx_r, idx_nxt;
  logic                  valid_r, valid_nxt;
  logic                  at_last;
  logic                  fire;

  // Output view of the current entry.
  always_comb begin
    at_last          = (idx_r == list_r.count - 1'b1);
    fire             = valid_r && out_ready;
    can_load         = !valid_r || (fire && at_last);
    out_valid        = valid_r;
    out_byte         = list_r.bytes[idx_r];
    out_run_end      = at_last;
    out_frame_end    = at_last && list_r.frame_close;
    out_length_error = list_r.err;
  end

  // Entry index and valid flag.
  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = '0;
      valid_nxt = (list_in.count != '0);
    end else if (fire) begin
      if (at_last) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Result list payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      list_r <= list_in;
    end
  end

endmodule

@@ hdl/beacon_frame_builder_fletcher_top.sv @@
// ----------------------------------------------------------------------------
// Beacon frame builder with Fletcher checksum, top level
// The first result byte is valid in the cycle after the input accept.
// Output: one result byte per cycle while out_ready is high (1 raw, 2 hex, up
// to 7 with header and sums); one result list register, reloaded as the last byte leaves.
// Reset: synchronous active-low rst_n clears sums, drop flag, output valid
// flag and index, and sets hex mode.
// ----------------------------------------------------------------------------
module beacon_frame_builder_fletcher_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic [7:0] in_frame_length,
  input  logic       in_first_item,
  input  logic       in_last_item,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_end,
  output logic       out_frame_end,
  output logic       out_length_error
);

  logic                  hex_mode_r;
  logic                  can_load;
  logic                  in_fire;
  bfb_pkg::result_list_t result_list;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      hex_mode_r <= cfg_wr_data;
    end
  end

  // Input transaction handshake.
  assign in_ready = can_load;
  assign in_fire  = in_valid && can_load;

  bfb_encode u_encode (
    .clk          (clk),
    .rst_n        (rst_n),
    .hex_mode     (hex_mode_r),
    .accept       (in_fire),
    .data_byte    (in_data_byte),
    .frame_length (in_frame_length),
    .first_item   (in_first_item),
    .last_item    (in_last_item),
    .result_list  (result_list)
  );

  bfb_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (in_fire),
    .list_in          (result_list),
    .can_load         (can_load),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_run_end      (out_run_end),
    .out_frame_end    (out_frame_end),
    .out_length_error (out_length_error)
  );

endmodule
